### rtl/dttod_pkg.sv
package dttod_pkg;

    localparam int FRACTION_BITS = 32;
    localparam int Q31_SHR       = (FRACTION_BITS >= 31) ? FRACTION_BITS - 31 : 0;
    localparam int Q31_SHL       = (FRACTION_BITS < 31) ? 31 - FRACTION_BITS : 0;

    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 192;
    localparam int M_DATA_W  = 128;

    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET         = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STEP        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DRIFT_ADJ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DRIFT_READ  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS_WHOLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS_FRAC   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIM  = 2'd3;

    localparam logic [31:0] TICK_RES_RST  = 32'd4294967;
    localparam logic [31:0] TPS_WHOLE_RST = 32'd1000;
    localparam logic [30:0] TPS_FRAC_RST  = 31'd0;
    localparam logic [30:0] DRIFT_LIM_RST = 31'd1073742;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRIFT,
        ST_PS_WHOLE,
        ST_PS_FRAC
    } state_t;

endpackage

### rtl/drift_trimmed_time_of_day_clock.sv
// Channel  Dir  tdata                                            tuser
// s_       in   set_time, step_delta, drift_request, error_est   kind
// m_       out  corrected_time, drift_per_second, jitter_average second_rolled
// cfg_     in   plain write port, index 0..3, no read-back
//
// An item passes accept, execute and two multiply steps; drift adjust adds
// a step after execute to turn the product into increment and correction.
// One shared 33x33 signed multiplier and one shared 64-bit adder do the multiplies and the 64-bit sums.
// Synchronous active-low reset clears time, offset, drift and jitter and loads
// the config and tick increment defaults.
// s_tready is high only while idle; a finished word waits in the output
// register, and the last step holds until that register is free.
module drift_trimmed_time_of_day_clock (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dttod_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dttod_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [63:0] set_time, [127:64] step_delta, [159:128] drift_request,
    // [191:160] error_estimate
    input  logic [dttod_pkg::S_DATA_W-1:0]     s_tdata,
    // [2:0] kind
    input  logic [dttod_pkg::KIND_W-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [63:0] corrected_time, [95:64] drift_per_second, [127:96] jitter_average
    output logic [dttod_pkg::M_DATA_W-1:0]     m_tdata,
    // [0] second_rolled
    output logic                               m_tuser
);

    dttod_pkg::state_t state_reg, state_next;

    logic [31:0] tick_res_reg;
    logic [31:0] tps_whole_reg;
    logic [30:0] tps_frac_reg;
    logic [30:0] drift_lim_reg;

    logic [63:0] raw_time_reg, raw_time_next;
    logic [63:0] time_offset_reg, time_offset_next;
    logic [32:0] tick_inc_reg, tick_inc_next;
    logic [31:0] drift_corr_reg, drift_corr_next;
    logic [31:0] jitter_reg, jitter_next;

    logic [dttod_pkg::KIND_W-1:0] kind_reg;
    logic [63:0] set_time_reg;
    logic [63:0] step_delta_reg;
    logic [31:0] drift_req_reg;
    logic [31:0] err_est_reg;

    logic [63:0] prod_reg, prod_next;
    logic [31:0] ps_whole_reg, ps_whole_next;
    logic [63:0] corr_time_reg, corr_time_next;
    logic        rolled_reg, rolled_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [dttod_pkg::M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;

    logic               accept;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic [63:0]        mul_p;
    logic [63:0]        add_a, add_b, add_sum;
    logic               add_cin;

    logic signed [32:0] req_ext, lim_pos, lim_neg;
    logic [31:0]        req_clamped;
    logic signed [32:0] jit_sum, jit_adj;
    logic [31:0]        clk_d;
    logic signed [63:0] clk_d_ext;
    logic [63:0]        q31_wide;
    logic [31:0]        ps_frac;
    logic               out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == dttod_pkg::ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // clamp the request against the limit on the way in
    assign req_ext = {s_tdata[159], s_tdata[159:128]};
    assign lim_pos = $signed({2'b00, drift_lim_reg});
    assign lim_neg = -lim_pos;
    always_comb begin
        if (req_ext > lim_pos) begin
            req_clamped = lim_pos[31:0];
        end else if (req_ext < lim_neg) begin
            req_clamped = lim_neg[31:0];
        end else begin
            req_clamped = req_ext[31:0];
        end
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[63:0];
    assign add_sum  = add_a + add_b + {63'd0, add_cin};

    assign jit_sum = $signed({jitter_reg[31], jitter_reg})
                   + $signed({err_est_reg[31], err_est_reg});
    assign jit_adj = jit_sum + $signed({32'd0, jit_sum[32] & jit_sum[0]});

    assign clk_d     = prod_reg[62:31];
    assign clk_d_ext = $signed({{32{clk_d[31]}}, clk_d});
    assign q31_wide  = 64'(clk_d_ext >>> dttod_pkg::Q31_SHR) << dttod_pkg::Q31_SHL;
    assign ps_frac   = mul_p[62:31];

    always_comb begin
        state_next       = state_reg;
        raw_time_next    = raw_time_reg;
        time_offset_next = time_offset_reg;
        tick_inc_next    = tick_inc_reg;
        drift_corr_next  = drift_corr_reg;
        jitter_next      = jitter_reg;
        prod_next        = prod_reg;
        ps_whole_next    = ps_whole_reg;
        corr_time_next   = corr_time_reg;
        rolled_next      = rolled_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        mul_a            = '0;
        mul_b            = '0;
        add_a            = raw_time_reg;
        add_b            = time_offset_reg;
        add_cin          = 1'b0;

        unique case (state_reg)
            dttod_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = dttod_pkg::ST_EXEC;
                end
            end
            dttod_pkg::ST_EXEC: begin
                rolled_next = 1'b0;
                state_next  = dttod_pkg::ST_PS_WHOLE;
                case (kind_reg)
                    dttod_pkg::KIND_TICK: begin
                        add_a         = raw_time_reg;
                        add_b         = {{31{tick_inc_reg[32]}}, tick_inc_reg};
                        raw_time_next = add_sum;
                        rolled_next   = add_sum[63:dttod_pkg::FRACTION_BITS]
                                     != raw_time_reg[63:dttod_pkg::FRACTION_BITS];
                    end
                    dttod_pkg::KIND_SET: begin
                        add_a            = set_time_reg;
                        add_b            = ~raw_time_reg;
                        add_cin          = 1'b1;
                        time_offset_next = add_sum;
                    end
                    dttod_pkg::KIND_STEP: begin
                        add_a            = time_offset_reg;
                        add_b            = step_delta_reg;
                        time_offset_next = add_sum;
                    end
                    dttod_pkg::KIND_DRIFT_ADJ: begin
                        mul_a       = $signed({drift_req_reg[31], drift_req_reg});
                        mul_b       = $signed({1'b0, tick_res_reg});
                        prod_next   = mul_p;
                        jitter_next = jit_adj[32:1];
                        state_next  = dttod_pkg::ST_DRIFT;
                    end
                    default: begin
                    end
                endcase
            end
            dttod_pkg::ST_DRIFT: begin
                drift_corr_next = q31_wide[31:0];
                tick_inc_next   = {1'b0, tick_res_reg} + {clk_d[31], clk_d};
                state_next      = dttod_pkg::ST_PS_WHOLE;
            end
            dttod_pkg::ST_PS_WHOLE: begin
                mul_a          = $signed({drift_corr_reg[31], drift_corr_reg});
                mul_b          = $signed({1'b0, tps_whole_reg});
                ps_whole_next  = mul_p[31:0];
                add_a          = raw_time_reg;
                add_b          = time_offset_reg;
                corr_time_next = add_sum;
                state_next     = dttod_pkg::ST_PS_FRAC;
            end
            dttod_pkg::ST_PS_FRAC: begin
                mul_a = $signed({drift_corr_reg[31], drift_corr_reg});
                mul_b = $signed({2'b00, tps_frac_reg});
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {jitter_reg, ps_whole_reg + ps_frac, corr_time_reg};
                    m_tuser_next  = rolled_reg;
                    state_next    = dttod_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dttod_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= dttod_pkg::ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            raw_time_reg    <= '0;
            time_offset_reg <= '0;
            tick_inc_reg    <= {1'b0, dttod_pkg::TICK_RES_RST};
            drift_corr_reg  <= '0;
            jitter_reg      <= '0;
            tick_res_reg    <= dttod_pkg::TICK_RES_RST;
            tps_whole_reg   <= dttod_pkg::TPS_WHOLE_RST;
            tps_frac_reg    <= dttod_pkg::TPS_FRAC_RST;
            drift_lim_reg   <= dttod_pkg::DRIFT_LIM_RST;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            raw_time_reg    <= raw_time_next;
            time_offset_reg <= time_offset_next;
            tick_inc_reg    <= tick_inc_next;
            drift_corr_reg  <= drift_corr_next;
            jitter_reg      <= jitter_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    dttod_pkg::CFG_TICK_RES:  tick_res_reg  <= cfg_wdata;
                    dttod_pkg::CFG_TPS_WHOLE: tps_whole_reg <= cfg_wdata;
                    dttod_pkg::CFG_TPS_FRAC:  tps_frac_reg  <= cfg_wdata[30:0];
                    dttod_pkg::CFG_DRIFT_LIM: drift_lim_reg <= cfg_wdata[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        ps_whole_reg  <= ps_whole_next;
        corr_time_reg <= corr_time_next;
        rolled_reg    <= rolled_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        if (accept) begin
            kind_reg       <= s_tuser;
            set_time_reg   <= s_tdata[63:0];
            step_delta_reg <= s_tdata[127:64];
            drift_req_reg  <= req_clamped;
            err_est_reg    <= s_tdata[191:160];
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("accepted a word while busy");

    a_clamp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dttod_pkg::ST_EXEC && kind_reg == dttod_pkg::KIND_DRIFT_ADJ)
        |-> ($signed({drift_req_reg[31], drift_req_reg}) <= lim_pos
             && $signed({drift_req_reg[31], drift_req_reg}) >= lim_neg))
        else $error("drift request outside limit");

    a_inc_only_on_drift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != dttod_pkg::ST_DRIFT) |=> $stable(tick_inc_reg))
        else $error("tick increment changed outside drift update");
`endif

endmodule
